// ----- design/tqs_pkg.sv -----
// Shared types and constants of the tone queue sequencer.
package tqs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int QAW         = $clog2(QUEUE_DEPTH);
    localparam int CW          = $clog2(QUEUE_DEPTH + 1);

    localparam int FREQ_W = 16;
    localparam int DUR_W  = 16;
    localparam int DUTY_W = 7;
    localparam int VOL_W  = 7;
    localparam int SLOT_W = 4;

    // volume * 127 / 100 as one multiply by a scaled reciprocal, shift 19
    localparam int          DUTY_SHIFT = 19;
    localparam logic [19:0] DUTY_RECIP = 20'd665861;
    localparam logic [6:0]  DUTY_MAX   = 7'd127;
    localparam logic [6:0]  DUTY_RESET = 7'd127;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic CFG_MUTED  = 1'b0;
    localparam logic CFG_VOLUME = 1'b1;

    typedef enum logic {
        S_IDLE,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [DUR_W-1:0]  dur;
    } t_tone;

    typedef struct packed {
        logic             we;
        logic [QAW-1:0]   addr;
        t_tone            data;
    } t_wr;

    typedef struct packed {
        logic              muted;
        logic [DUTY_W-1:0] duty;
    } t_cfg;

    typedef struct packed {
        logic          playing;
        logic          blocking;
        logic [CW-1:0] count;
    } t_status;

endpackage

// ----- design/tqs_if.sv -----
// Channel interfaces for input items and result items.
interface tqs_in_if import tqs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              operation;
    logic [FREQ_W-1:0] tone_frequency;
    logic [DUR_W-1:0]  tone_duration;
    logic              block_after;

    modport source (output valid, operation, tone_frequency, tone_duration, block_after,
                    input ready);
    modport sink   (input valid, operation, tone_frequency, tone_duration, block_after,
                    output ready);
endinterface

interface tqs_out_if import tqs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              accepted;
    logic              is_playing;
    logic [FREQ_W-1:0] drive_frequency;
    logic [DUTY_W-1:0] drive_duty;
    logic [SLOT_W-1:0] current_slot;

    modport source (output valid, accepted, is_playing, drive_frequency, drive_duty,
                    current_slot, input ready);
    modport sink   (input valid, accepted, is_playing, drive_frequency, drive_duty,
                    current_slot, output ready);
endinterface

// ----- design/tone_queue_sequencer.sv -----
// Top level of the buzzer tone queue sequencer.
//
//   channel   direction  transfer when       payload
//   i_in      in         valid & ready       operation, tone_frequency, tone_duration,
//                                            block_after
//   o_out     out        valid & ready       accepted, is_playing, drive_frequency,
//                                            drive_duty, current_slot
//   i_cfg_*   in         i_cfg_we            i_cfg_index, i_cfg_data
//
// A push or a tick that stays on its tone loads the result register directly; a tick
// that moves to the next queued tone goes through S_LOAD for the registered ring read.
// One item is in work at a time; the result register frees the input side as soon
// as the waiting result transfers. Reset is synchronous and empties the ring at once.
// A stalled output holds its result and holds off the next input.
module tone_queue_sequencer import tqs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tqs_in_if.sink           i_in,
    tqs_out_if.source        o_out,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [VOL_W-1:0] i_cfg_data
);

    logic              r_muted;
    logic [DUTY_W-1:0] r_duty;
    logic [26:0]       w_prod;
    logic [7:0]        w_quot;
    logic [DUTY_W-1:0] w_duty;
    t_cfg              w_cfg;
    t_wr               w_wr;
    logic [QAW-1:0]    w_raddr;
    t_tone             w_rdata;
    t_status           w_status;

    assign w_prod = 27'(i_cfg_data) * 27'(DUTY_RECIP);
    assign w_quot = w_prod[DUTY_SHIFT +: 8];
    assign w_duty = (w_quot > 8'(DUTY_MAX)) ? DUTY_MAX : w_quot[DUTY_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_muted <= 1'b0;
            r_duty  <= DUTY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MUTED:  r_muted <= i_cfg_data[0];
                CFG_VOLUME: r_duty  <= w_duty;
                default:    r_muted <= r_muted;
            endcase
        end
    end

    assign w_cfg.muted = r_muted;
    assign w_cfg.duty  = r_duty;

    tqs_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_out    (o_out),
        .i_cfg    (w_cfg),
        .o_wr     (w_wr),
        .o_raddr  (w_raddr),
        .i_rdata  (w_rdata),
        .o_status (w_status)
    );

    tqs_store u_store (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.count <= CW'(QUEUE_DEPTH))
        else $error("ring count above depth");

    a_play_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.playing == (w_status.count != '0))
        else $error("playing flag out of step with ring count");

    a_block_play: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.blocking |-> w_status.playing)
        else $error("blocking while idle");

    a_acc_play: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.accepted) |-> o_out.is_playing)
        else $error("accepted push reported while idle");

endmodule

// ----- design/tqs_store.sv -----
// Tone ring memory: one write port, one registered read port.
module tqs_store import tqs_pkg::*; (
    input  logic           i_clk,
    input  t_wr            i_wr,
    input  logic [QAW-1:0] i_raddr,
    output t_tone          o_rdata
);

    t_tone r_mem [QUEUE_DEPTH];
    t_tone r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/tqs_seq.sv -----
// Playback sequencer: ring pointers, timing, and result register.
module tqs_seq import tqs_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tqs_in_if.sink         i_in,
    tqs_out_if.source      o_out,
    input  t_cfg           i_cfg,
    output t_wr            o_wr,
    output logic [QAW-1:0] o_raddr,
    input  t_tone          i_rdata,
    output t_status        o_status
);

    t_state            r_state, n_state;
    logic [QAW-1:0]    r_wi, n_wi;
    logic [QAW-1:0]    r_ri, n_ri;
    logic [CW-1:0]     r_count, n_count;
    logic              r_playing, n_playing;
    logic              r_blocking, n_blocking;
    logic [DUR_W-1:0]  r_elapsed, n_elapsed;
    logic [FREQ_W-1:0] r_cur_freq, n_cur_freq;
    logic [DUR_W-1:0]  r_cur_dur, n_cur_dur;

    logic              r_ovalid;
    logic              r_acc, n_acc;
    logic              r_oplay;
    logic [FREQ_W-1:0] r_ofreq;
    logic [DUTY_W-1:0] r_oduty;
    logic [SLOT_W-1:0] r_oslot;

    logic              w_take;
    logic              w_push_ok;
    logic              w_advance;
    logic              w_load_out;
    logic              w_drain;
    logic [DUR_W-1:0]  w_elapsed_inc;
    logic [QAW-1:0]    w_wi_next;
    logic [QAW-1:0]    w_ri_next;

    assign w_drain = r_ovalid && o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && (!r_ovalid || o_out.ready);
    assign w_take = i_in.valid && i_in.ready;

    assign w_push_ok = !i_cfg.muted && !r_blocking && (i_in.tone_duration != '0)
                       && (r_count < CW'(QUEUE_DEPTH));
    assign w_elapsed_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + 1'b1;
    assign w_wi_next = (r_wi == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_wi + 1'b1;
    assign w_ri_next = (r_ri == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_ri + 1'b1;
    assign w_advance = w_take && (i_in.operation == OP_TICK) && !i_cfg.muted && r_playing
                       && (w_elapsed_inc >= r_cur_dur) && (r_count > CW'(1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_advance) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_wi       = r_wi;
        n_ri       = r_ri;
        n_count    = r_count;
        n_playing  = r_playing;
        n_blocking = r_blocking;
        n_elapsed  = r_elapsed;
        n_cur_freq = r_cur_freq;
        n_cur_dur  = r_cur_dur;
        n_acc      = 1'b0;
        w_load_out = 1'b0;
        o_wr.we    = 1'b0;
        o_wr.addr  = r_wi;
        o_wr.data  = '{freq: i_in.tone_frequency, dur: i_in.tone_duration};
        o_raddr    = w_ri_next;
        case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    w_load_out = !w_advance;
                    if (i_in.operation == OP_PUSH) begin
                        if (w_push_ok) begin
                            n_acc   = 1'b1;
                            o_wr.we = 1'b1;
                            if (!r_playing) begin
                                n_ri       = r_wi;
                                n_elapsed  = '0;
                                n_cur_freq = i_in.tone_frequency;
                                n_cur_dur  = i_in.tone_duration;
                                n_playing  = 1'b1;
                            end
                            n_wi    = w_wi_next;
                            n_count = r_count + 1'b1;
                            if (i_in.block_after) begin
                                n_blocking = 1'b1;
                            end
                        end
                    end else if (!i_cfg.muted && r_playing) begin
                        if (w_elapsed_inc < r_cur_dur) begin
                            n_elapsed = w_elapsed_inc;
                        end else if (w_advance) begin
                            n_ri      = w_ri_next;
                            n_count   = r_count - 1'b1;
                            n_elapsed = '0;
                        end else begin
                            n_playing  = 1'b0;
                            n_blocking = 1'b0;
                            n_wi       = '0;
                            n_ri       = '0;
                            n_count    = '0;
                            n_elapsed  = '0;
                            n_cur_freq = '0;
                        end
                    end
                end
            end
            S_LOAD: begin
                w_load_out = 1'b1;
                n_cur_freq = i_rdata.freq;
                n_cur_dur  = i_rdata.dur;
            end
            default: begin
                w_load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_wi       <= '0;
            r_ri       <= '0;
            r_count    <= '0;
            r_playing  <= 1'b0;
            r_blocking <= 1'b0;
            r_elapsed  <= '0;
            r_cur_freq <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_wi       <= n_wi;
            r_ri       <= n_ri;
            r_count    <= n_count;
            r_playing  <= n_playing;
            r_blocking <= n_blocking;
            r_elapsed  <= n_elapsed;
            r_cur_freq <= n_cur_freq;
            if (w_load_out) begin
                r_ovalid <= 1'b1;
            end else if (w_drain) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_dur <= n_cur_dur;
        if (w_load_out) begin
            r_acc   <= n_acc;
            r_oplay <= n_playing;
            r_ofreq <= (n_playing && n_cur_freq != '0) ? n_cur_freq : '0;
            r_oduty <= (n_playing && n_cur_freq != '0) ? i_cfg.duty : '0;
            r_oslot <= n_playing ? SLOT_W'(n_ri) : '0;
        end
    end

    assign o_out.valid           = r_ovalid;
    assign o_out.accepted        = r_acc;
    assign o_out.is_playing      = r_oplay;
    assign o_out.drive_frequency = r_ofreq;
    assign o_out.drive_duty      = r_oduty;
    assign o_out.current_slot    = r_oslot;

    assign o_status.playing  = r_playing;
    assign o_status.blocking = r_blocking;
    assign o_status.count    = r_count;

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the tone queue sequencer: directed tests, then random tone traffic.
`timescale 1ns / 100ps

module testbench;
    import tqs_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int REPORT_MAX  = 10;
    localparam int RANDOM_ITEMS = 1950;

    typedef struct packed {
        logic              op;
        logic [FREQ_W-1:0] freq;
        logic [DUR_W-1:0]  dur;
        logic              blk;
    } t_tone_item;

    typedef struct packed {
        logic              accepted;
        logic              playing;
        logic [FREQ_W-1:0] freq;
        logic [DUTY_W-1:0] duty;
        logic [SLOT_W-1:0] slot;
    } t_drive_result;

    typedef enum logic {
        MIX_PUSH_HEAVY,
        MIX_TICK_HEAVY
    } t_mix;

    logic i_clk;
    logic i_rst_n;
    logic             cfg_we;
    logic             cfg_index;
    logic [VOL_W-1:0] cfg_data;

    tqs_in_if  in_ch();
    tqs_out_if out_ch();

    tone_queue_sequencer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // predictor state
    logic [FREQ_W-1:0] ring_freq [QUEUE_DEPTH];
    logic [DUR_W-1:0]  ring_dur  [QUEUE_DEPTH];
    logic [QAW-1:0]    wr_slot;
    logic [QAW-1:0]    rd_slot;
    logic [CW-1:0]     tones_queued;
    logic              seq_playing;
    logic              seq_blocking;
    logic [DUR_W-1:0]  ms_elapsed;
    logic [FREQ_W-1:0] play_freq;
    logic              cfg_muted;
    logic [VOL_W-1:0]  cfg_volume;

    t_drive_result pending_drive_q [$];
    int  mismatch_count = 0;
    int  quiet_cycles = 0;
    int  item_total = 0;
    bit  no_idle = 0;

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_drive_result sequence_tone(t_tone_item item);
        t_drive_result r;
        int duty;
        r = '0;
        if (item.op == OP_PUSH) begin
            if (!(cfg_muted || seq_blocking || item.dur == 0 || tones_queued >= QUEUE_DEPTH)) begin
                ring_freq[wr_slot] = item.freq;
                ring_dur[wr_slot]  = item.dur;
                if (!seq_playing) begin
                    rd_slot     = wr_slot;
                    ms_elapsed  = '0;
                    play_freq   = item.freq;
                    seq_playing = 1'b1;
                end
                wr_slot      = wr_slot + 1'b1;
                tones_queued = tones_queued + 1'b1;
                if (item.blk)
                    seq_blocking = 1'b1;
                r.accepted = 1'b1;
            end
        end else if (!cfg_muted && seq_playing) begin
            if (ms_elapsed != '1)
                ms_elapsed = ms_elapsed + 1'b1;
            if (ms_elapsed >= ring_dur[rd_slot]) begin
                if (tones_queued > 1) begin
                    rd_slot      = rd_slot + 1'b1;
                    tones_queued = tones_queued - 1'b1;
                    ms_elapsed   = '0;
                    play_freq    = ring_freq[rd_slot];
                end else begin
                    seq_playing  = 1'b0;
                    seq_blocking = 1'b0;
                    wr_slot      = '0;
                    rd_slot      = '0;
                    tones_queued = '0;
                    ms_elapsed   = '0;
                    play_freq    = '0;
                end
            end
        end
        r.playing = seq_playing;
        if (seq_playing && play_freq != 0) begin
            duty = (int'(cfg_volume) * 127) / 100;
            if (duty > 127)
                duty = 127;
            r.freq = play_freq;
            r.duty = duty[DUTY_W-1:0];
        end
        r.slot = seq_playing ? rd_slot : '0;
        return r;
    endfunction

    task automatic send_item(input t_tone_item item);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.operation      = item.op;
        in_ch.tone_frequency = item.freq;
        in_ch.tone_duration  = item.dur;
        in_ch.block_after    = item.blk;
        in_ch.valid          = 1'b1;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        pending_drive_q.push_back(sequence_tone(item));
        item_total++;
        @(negedge i_clk);
    endtask

    task automatic push_tone(input logic [FREQ_W-1:0] freq, input logic [DUR_W-1:0] dur,
                             input logic blk);
        send_item('{op: OP_PUSH, freq: freq, dur: dur, blk: blk});
    endtask

    task automatic tick_ms(input int n);
        repeat (n) send_item('{op: OP_TICK, freq: 16'($urandom()), dur: 16'($urandom()),
                               blk: 1'($urandom())});
    endtask

    task automatic drain_results();
        in_ch.valid = 1'b0;
        while (pending_drive_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [VOL_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge i_clk);
        cfg_we = 1'b0;
        if (idx == CFG_MUTED)
            cfg_muted = value[0];
        else
            cfg_volume = value;
    endtask

    task automatic test_basic_playback();
        push_tone(16'hFFFF, 16'd1, 1'b0);
        push_tone(16'h0000, 16'd2, 1'b0);
        push_tone(16'h0001, 16'd3, 1'b1);
        push_tone(16'h1234, 16'hFFFF, 1'b0);
        tick_ms(6);
        tick_ms(1);
        push_tone(16'hABCD, 16'd0, 1'b1);
        drain_results();
    endtask

    task automatic test_volume_and_mute();
        write_reg(CFG_VOLUME, 7'd127);
        push_tone(16'h00FF, 16'd4, 1'b0);
        tick_ms(1);
        drain_results();
        write_reg(CFG_VOLUME, 7'd0);
        tick_ms(1);
        drain_results();
        write_reg(CFG_MUTED, 7'd1);
        tick_ms(1);
        push_tone(16'h5555, 16'd1, 1'b0);
        drain_results();
        write_reg(CFG_MUTED, 7'd0);
        write_reg(CFG_VOLUME, 7'd100);
        tick_ms(2);
        drain_results();
    endtask

    task automatic test_full_ring();
        for (int i = 0; i < QUEUE_DEPTH; i++)
            push_tone(16'($urandom()), 16'd1, 1'b0);
        push_tone(16'hFFFF, 16'hFFFF, 1'b1);
        tick_ms(QUEUE_DEPTH);
        drain_results();
    endtask

    function automatic t_tone_item make_item(t_mix mix);
        t_tone_item item;
        int push_pct;
        item.op   = OP_PUSH;
        item.freq = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom());
        item.blk  = ($urandom_range(0, 11) == 0);
        item.dur  = 16'($urandom_range(1, 12));
        push_pct  = (mix == MIX_PUSH_HEAVY) ? 70 : 30;
        if ($urandom_range(0, 99) < 15) begin
            item.blk = 1'($urandom());
            case ($urandom_range(0, 2))
                0: item.dur = '0;
                1: if (cfg_muted || seq_blocking || tones_queued >= QUEUE_DEPTH)
                       item.dur = 16'($urandom());
                   else
                       item.dur = '0;
                default: item.op = OP_TICK;
            endcase
        end else if ($urandom_range(0, 99) >= push_pct) begin
            item.op = OP_TICK;
        end
        return item;
    endfunction

    task automatic test_random_traffic();
        int phase_len;
        t_mix mix;
        while (item_total < RANDOM_ITEMS) begin
            drain_results();
            write_reg(CFG_MUTED, 7'($urandom_range(0, 9) == 0));
            case ($urandom_range(0, 4))
                0: write_reg(CFG_VOLUME, 7'd0);
                1: write_reg(CFG_VOLUME, 7'd100);
                2: write_reg(CFG_VOLUME, 7'd127);
                default: write_reg(CFG_VOLUME, 7'($urandom_range(0, 127)));
            endcase
            no_idle   = ($urandom_range(0, 3) == 0);
            mix       = t_mix'($urandom_range(0, 1));
            phase_len = cfg_muted ? 10 : $urandom_range(40, 80);
            repeat (phase_len) send_item(make_item(mix));
        end
        no_idle = 1'b0;
    endtask

    // result checker
    initial begin
        int stall;
        t_drive_result want;
        t_drive_result got;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                out_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!(i_rst_n && out_ch.valid === 1'b1));
            got = '{accepted: out_ch.accepted, playing: out_ch.is_playing,
                    freq: out_ch.drive_frequency, duty: out_ch.drive_duty,
                    slot: out_ch.current_slot};
            if (pending_drive_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result: acc=%0d play=%0d freq=%h duty=%0d slot=%0d",
                             got.accepted, got.playing, got.freq, got.duty, got.slot);
            end else begin
                want = pending_drive_q.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("mismatch: expected acc=%0d play=%0d freq=%h duty=%0d slot=%0d,",
                                 want.accepted, want.playing, want.freq, want.duty, want.slot,
                                 " got acc=%0d play=%0d freq=%h duty=%0d slot=%0d",
                                 got.accepted, got.playing, got.freq, got.duty, got.slot);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_MUTED;
        cfg_data             = '0;
        in_ch.valid          = 1'b0;
        in_ch.operation      = OP_PUSH;
        in_ch.tone_frequency = '0;
        in_ch.tone_duration  = '0;
        in_ch.block_after    = 1'b0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            ring_freq[i] = '0;
            ring_dur[i]  = '0;
        end
        wr_slot      = '0;
        rd_slot      = '0;
        tones_queued = '0;
        seq_playing  = 1'b0;
        seq_blocking = 1'b0;
        ms_elapsed   = '0;
        play_freq    = '0;
        cfg_muted    = 1'b0;
        cfg_volume   = 7'd100;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_basic_playback();
        test_volume_and_mute();
        test_full_ring();
        test_random_traffic();

        drain_results();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/tqs_pkg.sv
design/tqs_if.sv
design/tqs_store.sv
design/tqs_seq.sv
design/tone_queue_sequencer.sv
verif/testbench.sv
